// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the queue block RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define KQS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define KQS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/kqs_pkg.sv =====
// Package for the shared-store queue block: widths, status codes, write enables.
// No dependencies.
`timescale 1ns / 1ps

package kqs_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int SLOTS_DEF  = 16;
  localparam int QUEUES_DEF = 4;

  // Fixed payload widths
  localparam int DATA_W = 32;
  localparam int QID_W  = 2;
  localparam int STAT_W = 2;

  // Request kinds
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Response status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // Data returned by a dequeue from an empty queue
  localparam logic [DATA_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

  // Write strobes from the sequencer to the store
  typedef struct packed {
    logic link;
    logic data;
    logic head;
    logic tail;
  } kqs_wen_t;

endpackage

// ===== hw/rtl/kqs_req_if.sv =====
// Request channel: valid/ready handshake carrying one queue request.
// Depends on kqs_pkg.
`timescale 1ns / 1ps

interface kqs_req_if;
  import kqs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output queue_id, output data_in,
                  input ready);
  modport sink   (input valid, input req_type, input queue_id, input data_in,
                  output ready);
endinterface

// ===== hw/rtl/kqs_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one request result.
// Depends on kqs_pkg.
`timescale 1ns / 1ps

interface kqs_rsp_if;
  import kqs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output data_out, output status, input ready);
  modport sink   (input valid, input data_out, input status, output ready);
endinterface

// ===== hw/rtl/kqs_store.sv =====
// Storage for the queues: slot link and data memories, queue head and tail memories.
// Depends on kqs_pkg; all reads are registered, one write port per memory.
`timescale 1ns / 1ps

module kqs_store #(
  parameter int  SLOTS  = kqs_pkg::SLOTS_DEF,
  parameter int  QUEUES = kqs_pkg::QUEUES_DEF,
  localparam int IW     = $clog2(SLOTS),
  localparam int PW     = $clog2(SLOTS + 1),
  localparam int QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
  input  logic                        clk_i,
  input  kqs_pkg::kqs_wen_t           wen_i,
  input  logic [QW-1:0]               q_addr_i,
  input  logic [IW-1:0]               link_raddr_i,
  input  logic [IW-1:0]               link_waddr_i,
  input  logic [PW-1:0]               link_wdata_i,
  input  logic [IW-1:0]               data_raddr_i,
  input  logic [IW-1:0]               data_waddr_i,
  input  logic [kqs_pkg::DATA_W-1:0]  data_wdata_i,
  input  logic [PW-1:0]               head_wdata_i,
  input  logic [PW-1:0]               tail_wdata_i,
  output logic [PW-1:0]               head_rd_o,
  output logic [PW-1:0]               tail_rd_o,
  output logic [PW-1:0]               link_rd_o,
  output logic [kqs_pkg::DATA_W-1:0]  data_rd_o
);
  import kqs_pkg::*;

  logic [PW-1:0]     link_mem [SLOTS];
  logic [DATA_W-1:0] data_mem [SLOTS];
  logic [PW-1:0]     head_mem [QUEUES];
  logic [PW-1:0]     tail_mem [QUEUES];

  // Slot link memory
  always_ff @(posedge clk_i) begin
    if (wen_i.link) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rd_o <= link_mem[link_raddr_i];
  end

  // Slot data memory
  always_ff @(posedge clk_i) begin
    if (wen_i.data) begin
      data_mem[data_waddr_i] <= data_wdata_i;
    end
    data_rd_o <= data_mem[data_raddr_i];
  end

  // Queue head and tail memories, one shared queue address
  always_ff @(posedge clk_i) begin
    if (wen_i.head) begin
      head_mem[q_addr_i] <= head_wdata_i;
    end
    if (wen_i.tail) begin
      tail_mem[q_addr_i] <= tail_wdata_i;
    end
    head_rd_o <= head_mem[q_addr_i];
    tail_rd_o <= tail_mem[q_addr_i];
  end

endmodule

// ===== hw/rtl/kqs_seq.sv =====
// Sequencer for the queue block: clearing pass, per-request read/modify steps,
// free-list head and the result register. Depends on kqs_pkg, both channels and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kqs_seq #(
  parameter int  SLOTS    = kqs_pkg::SLOTS_DEF,
  parameter int  QUEUES   = kqs_pkg::QUEUES_DEF,
  localparam int IW       = $clog2(SLOTS),
  localparam int PW       = $clog2(SLOTS + 1),
  localparam int QW       = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kqs_req_if.sink                     req,
  kqs_rsp_if.source                   rsp,
  output kqs_pkg::kqs_wen_t           wen_o,
  output logic [QW-1:0]               q_addr_o,
  output logic [IW-1:0]               link_raddr_o,
  output logic [IW-1:0]               link_waddr_o,
  output logic [PW-1:0]               link_wdata_o,
  output logic [IW-1:0]               data_raddr_o,
  output logic [IW-1:0]               data_waddr_o,
  output logic [kqs_pkg::DATA_W-1:0]  data_wdata_o,
  output logic [PW-1:0]               head_wdata_o,
  output logic [PW-1:0]               tail_wdata_o,
  input  logic [PW-1:0]               head_rd_i,
  input  logic [PW-1:0]               tail_rd_i,
  input  logic [PW-1:0]               link_rd_i,
  input  logic [kqs_pkg::DATA_W-1:0]  data_rd_i
);
  import kqs_pkg::*;

  localparam int ClrDepth = (SLOTS > QUEUES) ? SLOTS : QUEUES;
  localparam int CW       = $clog2(ClrDepth);
  localparam logic [PW-1:0] NullPtr = PW'(SLOTS);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       clr_q, clr_d;
  logic [PW-1:0]       free_q, free_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q;
  logic [STAT_W-1:0]   out_stat_q;

  logic                deq_q;
  logic                qok_q;
  logic [QW-1:0]       qid_q;
  logic [DATA_W-1:0]   word_q;
  logic                ok_q;
  logic [PW-1:0]       slot_q;
  logic                head_null_q;
  logic [PW-1:0]       tail_q;
  logic [DATA_W-1:0]   res_data_q;
  logic [STAT_W-1:0]   res_stat_q;

  logic                accept;
  logic                load_out;
  logic                head_ok;
  logic                free_ok;
  logic                tail_ok;

  assign req.ready    = (state_q == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign rsp.valid    = out_valid_q;
  assign rsp.data_out = out_data_q;
  assign rsp.status   = out_stat_q;

  assign head_ok = (head_rd_i < NullPtr);
  assign free_ok = (free_q < NullPtr);
  assign tail_ok = (tail_q < NullPtr);

  // Sequence the store accesses for one transaction
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_d       = free_q;
    load_out     = 1'b0;
    wen_o        = '0;
    q_addr_o     = qid_q;
    link_raddr_o = deq_q ? head_rd_i[IW-1:0] : free_q[IW-1:0];
    data_raddr_o = head_rd_i[IW-1:0];
    link_waddr_o = slot_q[IW-1:0];
    link_wdata_o = NullPtr;
    data_waddr_o = slot_q[IW-1:0];
    data_wdata_o = word_q;
    head_wdata_o = slot_q;
    tail_wdata_o = slot_q;
    case (state_q)
      S_INIT: begin
        // Chain every slot into the free list and empty every queue
        q_addr_o     = clr_q[QW-1:0];
        link_waddr_o = clr_q[IW-1:0];
        link_wdata_o = PW'(clr_q) + PW'(1);
        head_wdata_o = NullPtr;
        wen_o.link   = (int'(clr_q) < SLOTS);
        wen_o.head   = (int'(clr_q) < QUEUES);
        clr_d        = clr_q + CW'(1);
        if (clr_q == CW'(ClrDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        q_addr_o = QW'(req.queue_id);
        if (accept) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = S_LINK;
      end
      S_LINK: begin
        state_d = S_DONE;
        if (ok_q && !deq_q) begin
          // Enqueue: pop the free list, write the word, append to the queue
          free_d     = link_rd_i;
          wen_o.data = 1'b1;
          wen_o.tail = 1'b1;
          if (head_null_q) begin
            wen_o.head = 1'b1;
            wen_o.link = 1'b1;
          end else begin
            link_waddr_o = tail_q[IW-1:0];
            link_wdata_o = slot_q;
            wen_o.link   = tail_ok;
            state_d      = S_FIX;
          end
        end else if (ok_q) begin
          // Dequeue: advance the head, push the slot onto the free list
          wen_o.head   = 1'b1;
          head_wdata_o = link_rd_i;
          wen_o.link   = 1'b1;
          link_wdata_o = free_q;
          free_d       = slot_q;
        end
      end
      S_FIX: begin
        // Terminate the newly appended slot
        wen_o.link = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !rsp.ready);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request, the decoded pointers and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      deq_q  <= (req.req_type == REQ_DEQ);
      qok_q  <= (int'(req.queue_id) < QUEUES);
      qid_q  <= QW'(req.queue_id);
      word_q <= req.data_in;
    end
    if (state_q == S_HEAD) begin
      ok_q        <= qok_q && (deq_q ? head_ok : free_ok);
      slot_q      <= deq_q ? head_rd_i : free_q;
      head_null_q <= !head_ok;
      tail_q      <= tail_rd_i;
    end
    if (state_q == S_LINK) begin
      if (deq_q) begin
        res_data_q <= ok_q ? data_rd_i : EMPTY_WORD;
        res_stat_q <= ok_q ? STATUS_OK : STATUS_EMPTY;
      end else begin
        res_data_q <= '0;
        res_stat_q <= ok_q ? STATUS_OK : STATUS_FULL;
      end
    end
    if (load_out) begin
      out_data_q <= res_data_q;
      out_stat_q <= res_stat_q;
    end
  end

  // Free-list head is a slot or null, never beyond
  `KQS_ASSERT(a_free_in_range, clk_i, rst_ni, free_q <= NullPtr)
  // A slot never links to itself
  `KQS_ASSERT_NEVER(a_no_self_link, clk_i, rst_ni, wen_o.link && (PW'(link_waddr_o) == link_wdata_o))
  // A good dequeue returns its slot to the free list
  `KQS_ASSERT(a_deq_frees_slot, clk_i, rst_ni, (state_q == S_LINK && ok_q && deq_q) |=> (free_q == $past(slot_q)))
  // A result appears only out of the hand-off step
  `KQS_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))

endmodule

// ===== hw/rtl/k_queues_shared_array.sv =====
// Each request runs through states HEAD (head and tail reads), LINK (dependent link and data
// reads, store writes) and DONE (response hand-off); an enqueue onto a non-empty queue also
// passes FIX to terminate the new slot. Request ready is high only in IDLE.
// The response register lets the next request in while a response waits to be taken.
// Reset: async, active low; then a clearing pass over every slot and queue with
// request ready held low, after which every slot is free and every queue empty.
`timescale 1ns / 1ps

module k_queues_shared_array #(
  parameter int SLOTS  = kqs_pkg::SLOTS_DEF,
  parameter int QUEUES = kqs_pkg::QUEUES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kqs_req_if.sink   req,
  kqs_rsp_if.source rsp
);
  import kqs_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  kqs_wen_t          wen;
  logic [QW-1:0]     q_addr;
  logic [IW-1:0]     link_raddr;
  logic [IW-1:0]     link_waddr;
  logic [PW-1:0]     link_wdata;
  logic [IW-1:0]     data_raddr;
  logic [IW-1:0]     data_waddr;
  logic [DATA_W-1:0] data_wdata;
  logic [PW-1:0]     head_wdata;
  logic [PW-1:0]     tail_wdata;
  logic [PW-1:0]     head_rd;
  logic [PW-1:0]     tail_rd;
  logic [PW-1:0]     link_rd;
  logic [DATA_W-1:0] data_rd;

  // Sequencer
  kqs_seq #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .rsp          (rsp),
    .wen_o        (wen),
    .q_addr_o     (q_addr),
    .link_raddr_o (link_raddr),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .data_raddr_o (data_raddr),
    .data_waddr_o (data_waddr),
    .data_wdata_o (data_wdata),
    .head_wdata_o (head_wdata),
    .tail_wdata_o (tail_wdata),
    .head_rd_i    (head_rd),
    .tail_rd_i    (tail_rd),
    .link_rd_i    (link_rd),
    .data_rd_i    (data_rd)
  );

  // Slot and queue storage
  kqs_store #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_store (
    .clk_i        (clk_i),
    .wen_i        (wen),
    .q_addr_i     (q_addr),
    .link_raddr_i (link_raddr),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .data_raddr_i (data_raddr),
    .data_waddr_i (data_waddr),
    .data_wdata_i (data_wdata),
    .head_wdata_i (head_wdata),
    .tail_wdata_i (tail_wdata),
    .head_rd_o    (head_rd),
    .tail_rd_o    (tail_rd),
    .link_rd_o    (link_rd),
    .data_rd_o    (data_rd)
  );

endmodule
